[hw/rtl/cdt_pkg.sv]
// Shared types and constants for the CSS declaration tokenizer.
// Holds the controller/datapath command and status structs; no dependencies.
package cdt_pkg;

	localparam int WS_HOLD_DEPTH = 32;
	localparam int HOLD_PTR_W    = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;
	localparam int HOLD_CNT_W    = $clog2(WS_HOLD_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_NAME     = 2'd0,
		KIND_VALUE    = 2'd1,
		KIND_END      = 2'd2,
		KIND_FINISHED = 2'd3
	} kind_t;

	// source of an emitted byte
	typedef enum logic [1:0] {
		BS_CH   = 2'd0,
		BS_HELD = 2'd1,
		BS_ZERO = 2'd2
	} bsel_t;

	typedef struct packed {
		logic  load_c;
		logic  emit;
		kind_t kind;
		bsel_t bsel;
		logic  unterm;
		logic  use_flag;
		logic  push;
		logic  pop;
		logic  rd;
		logic  clr;
		logic  set_flag;
		logic  load_quote;
		logic  finish;
	} cdt_cmd_t;

	typedef struct packed {
		logic ws;
		logic name;
		logic zero;
		logic slash;
		logic star;
		logic semi;
		logic eqcol;
		logic quote;
		logic qmatch;
		logic bslash;
		logic empty;
		logic full;
		logic emit_ok;
		logic pend_v;
	} cdt_status_t;

endpackage

[hw/rtl/cdt_datapath.sv]
// Datapath: input byte, character classes, trailing-whitespace hold store,
// result pending/output registers. Uses cdt_pkg; driven by cdt_ctrl.
module cdt_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           text_byte,
	input  cdt_pkg::cdt_cmd_t    cmd,
	input  logic                 plain,
	output cdt_pkg::cdt_status_t st,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [1:0]           kind,
	output logic [7:0]           out_byte,
	output logic                 unterminated,
	output logic                 trim_overflow,
	output logic                 last_of_run
);
	import cdt_pkg::*;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;

	logic [7:0]            c_q;
	logic [7:0]            quote_q;
	logic [7:0]            ch;
	logic [7:0]            hold_mem [WS_HOLD_DEPTH];
	logic [7:0]            rd_q;
	logic [HOLD_PTR_W-1:0] head_q;
	logic [HOLD_CNT_W-1:0] cnt_q;
	logic                  flag_q;
	logic [HOLD_CNT_W:0]   tail_sum;
	logic [HOLD_PTR_W-1:0] tail;
	logic [HOLD_PTR_W-1:0] head_inc;

	logic                  pend_v_q;
	kind_t                 pend_kind_q;
	logic [7:0]            pend_byte_q;
	logic                  pend_unterm_q;
	logic                  pend_ovf_q;
	logic                  out_v_q;
	kind_t                 out_kind_q;
	logic [7:0]            out_byte_q;
	logic                  out_unterm_q;
	logic                  out_ovf_q;
	logic                  out_last_q;

	logic                  emit_ok;
	logic                  fire_emit;
	logic                  move;
	logic [7:0]            emit_byte;

	assign ch = plain ? CH_SLASH : c_q;

	always_comb begin
		st.ws     = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
		st.name   = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
		            (ch >= 8'h61 && ch <= 8'h7A) || (ch == CH_DASH) || (ch == CH_UNDER);
		st.zero   = (ch == 8'd0);
		st.slash  = (ch == CH_SLASH);
		st.star   = (ch == CH_STAR);
		st.semi   = (ch == CH_SEMI);
		st.eqcol  = (ch == CH_EQ) || (ch == CH_COLON);
		st.quote  = (ch == CH_DQ) || (ch == CH_SQ);
		st.qmatch = (ch == quote_q);
		st.bslash = (ch == CH_BSL);
		st.empty  = (cnt_q == '0);
		st.full   = (cnt_q == HOLD_CNT_W'(WS_HOLD_DEPTH));
		st.emit_ok = emit_ok;
		st.pend_v  = pend_v_q;
	end

	// circular hold store: oldest byte at head, next free slot at head + count
	assign tail_sum = (HOLD_CNT_W+1)'(head_q) + (HOLD_CNT_W+1)'(cnt_q);
	assign tail     = (tail_sum >= (HOLD_CNT_W+1)'(WS_HOLD_DEPTH)) ?
	                  HOLD_PTR_W'(tail_sum - (HOLD_CNT_W+1)'(WS_HOLD_DEPTH)) :
	                  HOLD_PTR_W'(tail_sum);
	assign head_inc = (head_q == HOLD_PTR_W'(WS_HOLD_DEPTH - 1)) ? '0 :
	                  head_q + HOLD_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			hold_mem[tail] <= ch;
		end
		if (cmd.rd) begin
			rd_q <= hold_mem[head_q];
		end
		if (cmd.load_c) begin
			c_q <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			cnt_q   <= '0;
			flag_q  <= 1'b0;
			quote_q <= '0;
		end else begin
			if (cmd.clr) begin
				cnt_q  <= '0;
				flag_q <= 1'b0;
			end else if (cmd.push) begin
				cnt_q <= cnt_q + HOLD_CNT_W'(1);
			end else if (cmd.pop) begin
				cnt_q  <= cnt_q - HOLD_CNT_W'(1);
				head_q <= head_inc;
			end
			if (cmd.set_flag) begin
				flag_q <= 1'b1;
			end
			if (cmd.load_quote) begin
				quote_q <= ch;
			end
		end
	end

	// results wait in the pending slot until it is known whether more follow
	assign emit_ok   = !pend_v_q || !out_v_q || out_ready;
	assign fire_emit = cmd.emit && emit_ok;
	assign move      = pend_v_q && emit_ok && (cmd.emit || cmd.finish);

	always_comb begin
		case (cmd.bsel)
			BS_CH:   emit_byte = ch;
			BS_HELD: emit_byte = rd_q;
			BS_ZERO: emit_byte = 8'd0;
			default: emit_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (fire_emit) begin
				pend_v_q <= 1'b1;
			end else if (move) begin
				pend_v_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_emit) begin
			pend_kind_q   <= cmd.kind;
			pend_byte_q   <= emit_byte;
			pend_unterm_q <= cmd.unterm;
			pend_ovf_q    <= cmd.use_flag && flag_q;
		end
		if (move) begin
			out_kind_q   <= pend_kind_q;
			out_byte_q   <= pend_byte_q;
			out_unterm_q <= pend_unterm_q;
			out_ovf_q    <= pend_ovf_q;
			out_last_q   <= cmd.finish;
		end
	end

	assign out_valid     = out_v_q;
	assign kind          = out_kind_q;
	assign out_byte      = out_byte_q;
	assign unterminated  = out_unterm_q;
	assign trim_overflow = out_ovf_q;
	assign last_of_run   = out_last_q;

endmodule

[hw/rtl/cdt_ctrl.sv]
// Controller: sequencer and parse-phase state machine of the tokenizer.
// Uses cdt_pkg; issues commands to cdt_datapath and reads its status.
module cdt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cdt_pkg::cdt_status_t st,
	output cdt_pkg::cdt_cmd_t    cmd,
	output logic                 plain
);
	import cdt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_START = 6'b000010,
		S_EVAL  = 6'b000100,
		S_POPRD = 6'b001000,
		S_POPEM = 6'b010000,
		S_FIN   = 6'b100000
	} seq_t;

	typedef enum logic [15:0] {
		PH_NWS   = 16'h0001,
		PH_NCHK  = 16'h0002,
		PH_NCMT  = 16'h0004,
		PH_NBODY = 16'h0008,
		PH_PWS   = 16'h0010,
		PH_PCHK  = 16'h0020,
		PH_PCMT  = 16'h0040,
		PH_VWS   = 16'h0080,
		PH_VCHK  = 16'h0100,
		PH_VCMT  = 16'h0200,
		PH_VMAIN = 16'h0400,
		PH_ACHK  = 16'h0800,
		PH_ACMT  = 16'h1000,
		PH_QUOTE = 16'h2000,
		PH_ESC   = 16'h4000,
		PH_DONE  = 16'h8000
	} phase_t;

	seq_t   state_q, state_d;
	phase_t phase_q, phase_d;
	logic   slash_q, slash_d;
	logic   star_q, star_d;
	logic   plain_q, plain_d;
	logic   ret;

	assign in_ready = (state_q == S_IDLE);
	assign plain    = plain_q;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		slash_d = slash_q;
		star_d  = star_q;
		plain_d = plain_q;
		ret     = 1'b0;
		cmd     = '0;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_c = 1'b1;
					state_d    = S_START;
				end
			end
			S_START: begin
				if (slash_q) begin
					slash_d = 1'b0;
					if (st.star) begin
						star_d  = 1'b0;
						state_d = S_FIN;
						case (phase_q)
							PH_NCHK: phase_d = PH_NCMT;
							PH_PCHK: phase_d = PH_PCMT;
							PH_VCHK: phase_d = PH_VCMT;
							PH_VMAIN, PH_ACHK: phase_d = PH_ACMT;
							default: phase_d = phase_q;
						endcase
					end else begin
						plain_d = 1'b1;
						state_d = S_EVAL;
					end
				end else begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				case (phase_q)
					PH_NWS, PH_PWS, PH_VWS: begin
						if (st.ws) begin
							ret = 1'b1;
						end else if (phase_q == PH_NWS) begin
							phase_d = PH_NCHK;
						end else if (phase_q == PH_PWS) begin
							phase_d = PH_PCHK;
						end else begin
							phase_d = PH_VCHK;
						end
					end
					PH_NCMT, PH_PCMT, PH_VCMT, PH_ACMT: begin
						// a zero byte leaves the comment and is looked at again
						if (st.zero || (star_q && st.slash)) begin
							if (!st.zero) begin
								star_d = 1'b0;
								ret    = 1'b1;
							end
							case (phase_q)
								PH_NCMT: phase_d = PH_NCHK;
								PH_PCMT: phase_d = PH_PCHK;
								PH_VCMT: phase_d = PH_VCHK;
								default: phase_d = PH_ACHK;
							endcase
						end else begin
							star_d = st.star;
							ret    = 1'b1;
						end
					end
					PH_NBODY: begin
						if (st.name) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_NAME;
							ret      = 1'b1;
						end else begin
							phase_d = PH_PWS;
						end
					end
					PH_QUOTE, PH_ESC: begin
						if (st.zero) begin
							cmd.emit     = 1'b1;
							cmd.kind     = KIND_END;
							cmd.bsel     = BS_ZERO;
							cmd.unterm   = 1'b1;
							cmd.use_flag = 1'b1;
							cmd.clr      = 1'b1;
							phase_d      = PH_NWS;
						end else begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_VALUE;
							ret      = 1'b1;
							if (phase_q == PH_ESC) begin
								phase_d = PH_QUOTE;
							end else if (st.qmatch) begin
								phase_d = PH_VMAIN;
							end else if (st.bslash) begin
								phase_d = PH_ESC;
							end
						end
					end
					PH_DONE: begin
						if (st.zero) begin
							phase_d = PH_NWS;
						end
						ret = 1'b1;
					end
					default: begin
						if (st.slash && !plain_q) begin
							// hold the slash until the next byte tells if a comment opens
							slash_d = 1'b1;
							ret     = 1'b1;
						end else if (phase_q == PH_NCHK) begin
							cmd.emit = 1'b1;
							if (st.name) begin
								cmd.kind = KIND_NAME;
								phase_d  = PH_NBODY;
								ret      = 1'b1;
							end else begin
								cmd.kind = KIND_FINISHED;
								cmd.bsel = BS_ZERO;
								phase_d  = PH_DONE;
							end
						end else if (phase_q == PH_PCHK) begin
							if (st.eqcol) begin
								phase_d = PH_VWS;
								ret     = 1'b1;
							end else begin
								cmd.emit     = 1'b1;
								cmd.kind     = KIND_END;
								cmd.bsel     = BS_ZERO;
								cmd.use_flag = 1'b1;
								cmd.clr      = 1'b1;
								phase_d      = PH_NWS;
							end
						end else if (phase_q == PH_VCHK) begin
							phase_d = PH_VMAIN;
						end else if (phase_q == PH_VMAIN && st.quote) begin
							if (!st.empty) begin
								state_d = S_POPRD;
							end else begin
								cmd.clr        = 1'b1;
								cmd.emit       = 1'b1;
								cmd.kind       = KIND_VALUE;
								cmd.load_quote = 1'b1;
								phase_d        = PH_QUOTE;
								ret            = 1'b1;
							end
						end else if (st.semi || st.zero) begin
							cmd.emit     = 1'b1;
							cmd.kind     = KIND_END;
							cmd.bsel     = BS_ZERO;
							cmd.use_flag = 1'b1;
							cmd.clr      = 1'b1;
							phase_d      = PH_NWS;
							ret          = st.semi;
						end else if (st.ws) begin
							if (st.full) begin
								// store full: leak the oldest byte, then retry the push
								cmd.set_flag = 1'b1;
								state_d      = S_POPRD;
							end else begin
								cmd.push = 1'b1;
								phase_d  = PH_VMAIN;
								ret      = 1'b1;
							end
						end else if (!st.empty) begin
							state_d = S_POPRD;
						end else begin
							cmd.clr  = 1'b1;
							cmd.emit = 1'b1;
							cmd.kind = KIND_VALUE;
							phase_d  = PH_VMAIN;
							ret      = 1'b1;
						end
					end
				endcase
				if (ret) begin
					if (plain_q) begin
						plain_d = 1'b0;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_POPRD: begin
				cmd.rd  = 1'b1;
				state_d = S_POPEM;
			end
			S_POPEM: begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_VALUE;
				cmd.bsel = BS_HELD;
				cmd.pop  = 1'b1;
				state_d  = S_EVAL;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// result path full: hold everything for this cycle
		if ((cmd.emit || (cmd.finish && st.pend_v)) && !st.emit_ok) begin
			cmd     = '0;
			state_d = state_q;
			phase_d = phase_q;
			slash_d = slash_q;
			star_d  = star_q;
			plain_d = plain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_NWS;
			slash_q <= 1'b0;
			star_q  <= 1'b0;
			plain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			slash_q <= slash_d;
			star_q  <= star_d;
			plain_q <= plain_d;
		end
	end

endmodule

[hw/rtl/css_declaration_tokenizer_unit.sv]
// Top level of the CSS inline-style declaration tokenizer.
// Depends on cdt_pkg, cdt_ctrl and cdt_datapath.
//
// Takes one byte of an inline style string per input transfer (0 ends the
// string) and streams out name bytes, value bytes, one declaration-end per
// declaration and a parsing-finished marker; last_of_run marks the final
// result caused by an input byte. From a byte's transfer to the next possible
// input transfer the sequencer goes through accept, start, one step of the
// phase machine and finish; every extra step of the phase machine (a phase
// change that reexamines the same byte, or a held slash replayed in front of
// it) is added to that sequence, and each step gives at most one result. Each
// held whitespace byte that gets flushed or leaked adds a hold-store read, an
// emit and a reevaluation. A slash followed by a star opens a comment through
// accept, start and finish. The sequencer takes one step per cycle unless the
// result path stalls it, and the whitespace hold store has a registered read
// port. Results leave through a pending slot and an output register, so a
// stalled output only stops the block when both are full. Up to WS_HOLD_DEPTH
// trailing whitespace bytes are held back and dropped at the declaration end.
module css_declaration_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       unterminated,
	output logic       trim_overflow,
	output logic       last_of_run
);
	import cdt_pkg::*;

	cdt_cmd_t    cmd;
	cdt_status_t st;
	logic        plain;  // replaying a held slash ahead of the current byte

	cdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd),
		.plain    (plain)
	);

	cdt_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_byte     (text_byte),
		.cmd           (cmd),
		.plain         (plain),
		.st            (st),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.kind          (kind),
		.out_byte      (out_byte),
		.unterminated  (unterminated),
		.trim_overflow (trim_overflow),
		.last_of_run   (last_of_run)
	);

endmodule

[tb/tb_css_declaration_tokenizer_unit.sv]
// Self-checking bench for css_declaration_tokenizer_unit: directed table, then random strings.
// Each transfer is scored against a token predictor kept in this file.
// Depends on cdt_pkg (kind_t, WS_HOLD_DEPTH) and the tokenizer RTL.
module tb_css_declaration_tokenizer_unit;
	import cdt_pkg::*;

	localparam int RANDOM_ITEMS = 90;
	localparam int LONG_HOLD    = 300;  // receiver hold-off, in cycles
	localparam int DRAIN_CYCLES = 64;   // quiet time after the last expected token
	localparam int RUN_LIMIT    = 5_000_000;

	// character codes the tokenizer reacts to
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_HIGH   = 8'hFF;
	localparam logic [7:0] CH_ODD    = 8'h80;

	localparam string NAME_SET =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_";

	// Scan phases. The order matters: skip, check and comment phases of one
	// context are adjacent, and the predictor steps between them by +1 / -1.
	typedef enum logic [3:0] {
		SK_NAME, CK_NAME, CM_NAME, IN_NAME,
		SK_PAIR, CK_PAIR, CM_PAIR,
		SK_VAL, CK_VAL, CM_VAL, IN_VAL,
		CK_AFT, CM_AFT,
		IN_QUOTE, IN_ESC, FINISHED
	} phase_t;

	typedef struct packed {
		kind_t      k;
		logic [7:0] b;
		logic       ut;
		logic       ov;
		logic       lr;
	} token_t;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;  // tok holds the expected single token
		token_t     tok;
	} row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] text_byte = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       unterminated;
	logic       trim_overflow;
	logic       last_of_run;

	// predictor state, at its reset values
	phase_t     ph            = SK_NAME;
	logic       slash_pending = 1'b0;
	logic       star_prev     = 1'b0;
	logic [7:0] quote_ch      = 8'h00;
	logic [7:0] ws_hold [WS_HOLD_DEPTH];
	int         ws_cnt        = 0;
	logic       leak_flag     = 1'b0;

	token_t     step_toks[$];     // tokens caused by the byte just taken
	token_t     pending_toks[$];  // tokens still owed by the block
	logic [7:0] text_q[$];        // bytes of the string being sent

	int fault_count   = 0;
	int live_bytes    = 0;  // random bytes that the block does not just drop
	bit tx_idles      = 1'b1;
	bit rx_idles      = 1'b1;
	bit long_hold_req = 1'b0;

	// Directed table. Typed rows carry the one token the byte must cause.
	row_t dir_rows [26] = '{
		'{CH_NUL,    1'b1, '{KIND_FINISHED, 8'h00, 1'b0, 1'b0, 1'b1}},  // empty string
		'{"a",       1'b1, '{KIND_NAME, "a", 1'b0, 1'b0, 1'b1}},
		'{CH_SLASH,  1'b0, '0},  // comment between name and colon
		'{CH_STAR,   1'b0, '0},
		'{CH_STAR,   1'b0, '0},
		'{CH_SLASH,  1'b0, '0},
		'{CH_COLON,  1'b0, '0},
		'{CH_DQUOTE, 1'b0, '0},  // quoted value with an escape
		'{CH_BSLASH, 1'b0, '0},
		'{CH_HIGH,   1'b1, '{KIND_VALUE, CH_HIGH, 1'b0, 1'b0, 1'b1}},
		'{CH_DQUOTE, 1'b0, '0},
		'{CH_SPACE,  1'b0, '0},  // held, then a comment inside the value
		'{CH_SLASH,  1'b0, '0},
		'{CH_STAR,   1'b0, '0},
		'{CH_STAR,   1'b0, '0},
		'{CH_SLASH,  1'b0, '0},
		'{CH_SQUOTE, 1'b0, '0},  // right after a comment: taken plainly
		'{CH_SEMI,   1'b1, '{KIND_END, 8'h00, 1'b0, 1'b0, 1'b1}},
		'{"b",       1'b0, '0},
		'{CH_SEMI,   1'b0, '0},  // bare name, then no name found
		'{CH_ODD,    1'b0, '0},  // dropped after finish
		'{CH_NUL,    1'b0, '0},  // re-arms silently
		'{"c",       1'b0, '0},
		'{CH_EQ,     1'b0, '0},
		'{CH_SQUOTE, 1'b0, '0},
		'{CH_NUL,    1'b0, '0}   // unterminated quote
	};

	css_declaration_tokenizer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_byte     (text_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.out_byte      (out_byte),
		.unterminated  (unterminated),
		.trim_overflow (trim_overflow),
		.last_of_run   (last_of_run)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Token predictor
	// ---------------------------------------------------------------
	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_name_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || c == CH_DASH || c == CH_USCORE;
	endfunction

	function automatic void put_tok(input kind_t k, input logic [7:0] b, input logic ut,
			input logic ov);
		token_t t;
		t.k  = k;
		t.b  = b;
		t.ut = ut;
		t.ov = ov;
		t.lr = 1'b0;
		step_toks.push_back(t);
	endfunction

	function automatic void close_decl(input logic ut);
		put_tok(KIND_END, 8'h00, ut, leak_flag);
		ws_cnt    = 0;
		leak_flag = 1'b0;
	endfunction

	function automatic void flush_ws();
		for (int i = 0; i < ws_cnt && i < WS_HOLD_DEPTH; i++)
			put_tok(KIND_VALUE, ws_hold[i], 1'b0, 1'b0);
		ws_cnt    = 0;
		leak_flag = 1'b0;
	endfunction

	// Whitespace is held back; a full store leaks its oldest byte.
	function automatic void value_byte(input logic [7:0] c);
		if (is_space(c)) begin
			if (ws_cnt >= WS_HOLD_DEPTH) begin
				put_tok(KIND_VALUE, ws_hold[0], 1'b0, 1'b0);
				for (int i = 0; i < WS_HOLD_DEPTH - 1; i++)
					ws_hold[i] = ws_hold[i + 1];
				ws_cnt    = WS_HOLD_DEPTH - 1;
				leak_flag = 1'b1;
			end
			ws_hold[ws_cnt] = c;
			ws_cnt++;
		end else begin
			flush_ws();
			put_tok(KIND_VALUE, c, 1'b0, 1'b0);
		end
	endfunction

	// A byte known not to open a comment; returns 1 when it is used up.
	function automatic bit settle(input logic [7:0] c);
		case (ph)
			CK_NAME: begin
				if (is_name_char(c)) begin
					put_tok(KIND_NAME, c, 1'b0, 1'b0);
					ph = IN_NAME;
					return 1'b1;
				end
				put_tok(KIND_FINISHED, 8'h00, 1'b0, 1'b0);
				ph = FINISHED;
				return 1'b0;
			end
			CK_PAIR: begin
				if (c == CH_EQ || c == CH_COLON) begin
					ph = SK_VAL;
					return 1'b1;
				end
				close_decl(1'b0);
				ph = SK_NAME;
				return 1'b0;
			end
			CK_VAL: begin
				ph = IN_VAL;
				return 1'b0;
			end
			IN_VAL: begin
				if (c == CH_DQUOTE || c == CH_SQUOTE) begin
					flush_ws();
					put_tok(KIND_VALUE, c, 1'b0, 1'b0);
					quote_ch = c;
					ph       = IN_QUOTE;
					return 1'b1;
				end
			end
			default: ;
		endcase
		if (c == CH_SEMI) begin
			close_decl(1'b0);
			ph = SK_NAME;
			return 1'b1;
		end
		if (c == CH_NUL) begin
			close_decl(1'b0);
			ph = SK_NAME;
			return 1'b0;
		end
		value_byte(c);
		ph = IN_VAL;
		return 1'b1;
	endfunction

	// plain: a slash already known not to start a comment
	function automatic void scan(input logic [7:0] c, input bit plain);
		forever begin
			case (ph)
				SK_NAME, SK_PAIR, SK_VAL: begin
					if (is_space(c))
						return;
					ph = phase_t'(ph + 1);
				end
				CM_NAME, CM_PAIR, CM_VAL, CM_AFT: begin
					if (c == CH_NUL) begin
						ph = phase_t'(ph - 1);
					end else if (star_prev && c == CH_SLASH) begin
						star_prev = 1'b0;
						ph        = phase_t'(ph - 1);
						return;
					end else begin
						star_prev = (c == CH_STAR);
						return;
					end
				end
				IN_NAME: begin
					if (is_name_char(c)) begin
						put_tok(KIND_NAME, c, 1'b0, 1'b0);
						return;
					end
					ph = SK_PAIR;
				end
				IN_QUOTE, IN_ESC: begin
					if (c == CH_NUL) begin
						close_decl(1'b1);
						ph = SK_NAME;
					end else begin
						put_tok(KIND_VALUE, c, 1'b0, 1'b0);
						if (ph == IN_ESC)
							ph = IN_QUOTE;
						else if (c == quote_ch)
							ph = IN_VAL;
						else if (c == CH_BSLASH)
							ph = IN_ESC;
						return;
					end
				end
				FINISHED: begin
					if (c == CH_NUL)
						ph = SK_NAME;
					return;
				end
				default: begin
					// slash lookahead: decided by the next byte
					if (c == CH_SLASH && !plain) begin
						slash_pending = 1'b1;
						return;
					end
					if (settle(c))
						return;
				end
			endcase
		end
	endfunction

	function automatic void tokenize_byte(input logic [7:0] c);
		step_toks.delete();
		if (slash_pending) begin
			slash_pending = 1'b0;
			if (c == CH_STAR) begin
				if (ph == IN_VAL || ph == CK_AFT)
					ph = CM_AFT;
				else
					ph = phase_t'(ph + 1);
				star_prev = 1'b0;
			end else begin
				scan(CH_SLASH, 1'b1);
				scan(c, 1'b0);
			end
		end else begin
			scan(c, 1'b0);
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].lr = 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// String generation
	// ---------------------------------------------------------------
	function automatic void add_ws(input int n);
		int k;
		repeat (n) begin
			k = $urandom_range(0, 5);
			text_q.push_back(k == 5 ? CH_SPACE : 8'(9 + k));
		end
	endfunction

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		c = 8'($urandom_range(33, 126));
		if (c == CH_SEMI || c == CH_DQUOTE || c == CH_SQUOTE || c == CH_SLASH)
			c = "x";
		return c;
	endfunction

	function automatic void add_comment();
		text_q.push_back(CH_SLASH);
		text_q.push_back(CH_STAR);
		repeat ($urandom_range(0, 4))
			text_q.push_back(word_char());
		text_q.push_back(CH_STAR);
		text_q.push_back(CH_SLASH);
	endfunction

	function automatic void add_name(input int n);
		repeat (n)
			text_q.push_back(NAME_SET[$urandom_range(0, NAME_SET.len() - 1)]);
	endfunction

	// One name:value pair with random spacing, comments and value pieces.
	function automatic void add_decl();
		logic [7:0] q;
		if ($urandom_range(0, 2) == 0)
			add_ws($urandom_range(1, 3));
		if ($urandom_range(0, 5) == 0)
			add_comment();
		add_name($urandom_range(1, 6));
		if ($urandom_range(0, 3) == 0)
			add_ws($urandom_range(1, 2));
		if ($urandom_range(0, 7) == 0)
			add_comment();
		if ($urandom_range(0, 7) == 0)
			return;  // bare name
		text_q.push_back($urandom_range(0, 1) ? CH_COLON : CH_EQ);
		if ($urandom_range(0, 1) == 0)
			add_ws($urandom_range(1, 2));
		if ($urandom_range(0, 6) == 0)
			add_comment();
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3, 4: begin
					repeat ($urandom_range(1, 5))
						text_q.push_back(word_char());
				end
				5, 6: add_ws($urandom_range(1, 3));
				7: begin
					q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
					text_q.push_back(q);
					repeat ($urandom_range(0, 4)) begin
						if ($urandom_range(0, 3) == 0)
							text_q.push_back(CH_BSLASH);
						text_q.push_back(8'($urandom_range(32, 126)));
					end
					text_q.push_back(q);
				end
				8: add_comment();
				9: text_q.push_back(8'($urandom_range(128, 255)));
				10: add_ws($urandom_range(WS_HOLD_DEPTH + 1, WS_HOLD_DEPTH + 6));
				default: text_q.push_back(CH_SLASH);  // slash that opens nothing
			endcase
		end
		if ($urandom_range(0, 1) == 0)
			add_ws($urandom_range(1, 3));
	endfunction

	// ---------------------------------------------------------------
	// Sender: one transfer per call, called and returning just after a falling edge
	// ---------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic typed, input token_t tok);
		if (tx_idles && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (!in_ready);
		// bytes after a finish, other than 0, are just dropped
		if (ph != FINISHED || b == CH_NUL)
			live_bytes++;
		tokenize_byte(b);
		if (typed)
			pending_toks.push_back(tok);
		else
			foreach (step_toks[i])
				pending_toks.push_back(step_toks[i]);
		@(negedge clk);
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (rx_idles && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Scoreboard: every result transfer against the oldest token owed.
	always @(posedge clk) begin
		token_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_toks.size() == 0) begin
				fault_count++;
				$display("%0t: unexpected result kind %0d byte %h unterm %b ovf %b last %b",
					$time, kind, out_byte, unterminated, trim_overflow, last_of_run);
			end else begin
				want = pending_toks.pop_front();
				if (want.k !== kind || want.b !== out_byte || want.ut !== unterminated ||
						want.ov !== trim_overflow || want.lr !== last_of_run) begin
					fault_count++;
					$display("%0t: mismatch expected kind %0d byte %h unterm %b ovf %b last %b",
						$time, want.k, want.b, want.ut, want.ov, want.lr);
					$display("%0t:          actual   kind %0d byte %h unterm %b ovf %b last %b",
						$time, kind, out_byte, unterminated, trim_overflow, last_of_run);
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#(RUN_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		bit paused;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].tok);

		// Long name while the receiver holds off: the output path fills and
		// the input side has to stall.
		live_bytes    = 0;
		long_hold_req = 1'b1;
		text_q.delete();
		add_name(40);
		text_q.push_back(CH_NUL);
		foreach (text_q[i])
			send_byte(text_q[i], 1'b0, '0);

		while (live_bytes < RANDOM_ITEMS) begin
			// sender pauses once until the block has drained
			if (!paused && live_bytes >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				while (pending_toks.size() != 0) @(posedge clk);
				@(negedge clk);
			end
			// the tail of the run goes at full rate on both sides
			if (live_bytes >= RANDOM_ITEMS - 40) begin
				tx_idles = 1'b0;
				rx_idles = 1'b0;
			end
			text_q.delete();
			case ($urandom_range(0, 9))
				0: begin  // raw noise, zeros included
					repeat ($urandom_range(5, 15))
						text_q.push_back(8'($urandom_range(0, 255)));
				end
				1: begin  // value cut off inside a quote
					add_decl();
					text_q.push_back(CH_COLON);
					text_q.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
					repeat ($urandom_range(0, 3))
						text_q.push_back(word_char());
					if ($urandom_range(0, 1) == 0)
						text_q.push_back(CH_BSLASH);
					text_q.push_back(CH_NUL);
				end
				2: begin  // no name at the start; the rest is dropped
					text_q.push_back(CH_SEMI);
					repeat ($urandom_range(2, 6))
						text_q.push_back(8'($urandom_range(1, 255)));
					text_q.push_back(CH_NUL);
				end
				default: begin
					repeat ($urandom_range(1, 4)) begin
						add_decl();
						if ($urandom_range(0, 4) != 0)
							text_q.push_back(CH_SEMI);
					end
					text_q.push_back(CH_NUL);
				end
			endcase
			foreach (text_q[i])
				send_byte(text_q[i], 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_toks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
